// File: sv/umtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umtc_pkg
// Shared types and codes for the uart mux transaction controller.
// ----------------------------------------------------------------------------
package umtc_pkg;

  // command codes
  typedef enum logic [3:0] {
    CMD_INIT    = 4'd0,
    CMD_DEINIT  = 4'd1,
    CMD_BIND    = 4'd2,
    CMD_ENABLE  = 4'd3,
    CMD_DISABLE = 4'd4,
    CMD_SELECT  = 4'd5,
    CMD_GETCHAN = 4'd6,
    CMD_TX      = 4'd7,
    CMD_RX      = 4'd8,
    CMD_ABORT   = 4'd9,
    CMD_TXDONE  = 4'd10,
    CMD_RXDONE  = 4'd11,
    CMD_ERROR   = 4'd12
  } cmd_e;

  // bus modes
  typedef enum logic [1:0] {
    MODE_UNINIT = 2'd0,
    MODE_IDLE   = 2'd1,
    MODE_ACTIVE = 2'd2,
    MODE_ERROR  = 2'd3
  } mode_e;

  // status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PARAM    = 3'd1,
    ST_NOT_INIT = 3'd2,
    ST_BUSY     = 3'd3,
    ST_STATE    = 3'd4,
    ST_TIMEOUT  = 3'd5,
    ST_IO       = 3'd6,
    ST_OVERFLOW = 3'd7
  } status_e;

  // event kinds
  typedef enum logic [1:0] {
    EV_TX_DONE = 2'd0,
    EV_RX_DONE = 2'd1,
    EV_FAULT   = 2'd2
  } ev_kind_e;

  localparam logic [2:0] NO_CHANNEL = 3'd4;

  // controller state
  typedef struct packed {
    logic        initialized;
    mode_e       bus_mode;
    logic        enabled;
    logic [2:0]  cur_channel;
    logic [1:0]  sel_pins;
    logic        tx_busy;
    logic        rx_busy;
    logic [15:0] rx_limit;
    logic        sink_bound;
  } umtc_state_t;

  // one command request
  typedef struct packed {
    logic [3:0]  command;
    logic [2:0]  channel;
    logic [15:0] length;
    logic [1:0]  port_status;
    logic [31:0] raw_error;
    logic        sink_flag;
  } umtc_req_t;

  // one result
  typedef struct packed {
    status_e     status;
    mode_e       bus_state;
    logic [2:0]  channel_out;
    logic        mux_enabled;
    logic [1:0]  select_lines;
    logic        ev_valid;
    ev_kind_e    ev_kind;
    status_e     ev_status;
    logic [15:0] ev_length;
    logic [31:0] ev_error;
  } umtc_result_t;

  // platform outcome to status
  function automatic status_e map_port(input logic [1:0] p);
    status_e s;
    case (p)
      2'd0:    s = ST_OK;
      2'd1:    s = ST_BUSY;
      2'd2:    s = ST_TIMEOUT;
      default: s = ST_IO;
    endcase
    return s;
  endfunction

endpackage

// File: sv/umtc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umtc_step
// Command decode: next controller state and result for one request.
// ----------------------------------------------------------------------------
module umtc_step #(
  parameter int CHANNELS = 4
) (
  input  umtc_pkg::umtc_state_t  state_i,
  input  umtc_pkg::umtc_req_t    req_i,
  output umtc_pkg::umtc_state_t  state_o,
  output umtc_pkg::umtc_result_t result_o
);
  import umtc_pkg::*;

  localparam logic [3:0] ChanLimit = 4'(CHANNELS);

  umtc_state_t s;
  umtc_state_t n;
  status_e     st;
  status_e     idle_st;
  status_e     port_st;
  logic        ev_valid;
  ev_kind_e    ev_kind;
  status_e     ev_status;
  logic [15:0] ev_length;
  logic [31:0] ev_error;
  logic        req_ch_ok;
  logic        cur_ch_ok;
  logic        start_fail;
  status_e     start_st;

  assign s = state_i;

  // mode follows the activity flags unless the bus is in error
  function automatic mode_e sync_mode(input mode_e m, input logic tx, input logic rx);
    mode_e r;
    if (m == MODE_ERROR) begin
      r = MODE_ERROR;
    end else if (tx || rx) begin
      r = MODE_ACTIVE;
    end else begin
      r = MODE_IDLE;
    end
    return r;
  endfunction

  // bus reset, select pins keep their level
  function automatic umtc_state_t clear_bus(input umtc_state_t c);
    umtc_state_t r;
    r             = c;
    r.initialized = 1'b0;
    r.enabled     = 1'b0;
    r.cur_channel = NO_CHANNEL;
    r.bus_mode    = MODE_UNINIT;
    r.tx_busy     = 1'b0;
    r.rx_busy     = 1'b0;
    r.rx_limit    = '0;
    r.sink_bound  = 1'b0;
    return r;
  endfunction

  // shared checks
  always_comb begin
    req_ch_ok = {1'b0, req_i.channel} < ChanLimit;
    cur_ch_ok = {1'b0, s.cur_channel} < ChanLimit;
    port_st   = map_port(req_i.port_status);

    if (!s.initialized) begin
      idle_st = ST_NOT_INIT;
    end else if (s.bus_mode == MODE_ACTIVE || s.tx_busy || s.rx_busy) begin
      idle_st = ST_BUSY;
    end else if (s.bus_mode != MODE_IDLE) begin
      idle_st = ST_STATE;
    end else begin
      idle_st = ST_OK;
    end

    // transfer start checks, busy flag picked by direction
    start_fail = 1'b1;
    if (!s.initialized) begin
      start_st = ST_NOT_INIT;
    end else if (s.bus_mode == MODE_ERROR || s.bus_mode == MODE_UNINIT) begin
      start_st = ST_STATE;
    end else if ((req_i.command == CMD_TX) ? s.tx_busy : s.rx_busy) begin
      start_st = ST_BUSY;
    end else if (!s.enabled || !cur_ch_ok || !s.sink_bound) begin
      start_st = ST_STATE;
    end else begin
      start_st   = ST_OK;
      start_fail = 1'b0;
    end
  end

  // command decode
  always_comb begin
    n         = s;
    st        = ST_OK;
    ev_valid  = 1'b0;
    ev_kind   = EV_TX_DONE;
    ev_status = ST_OK;
    ev_length = '0;
    ev_error  = '0;

    case (req_i.command)
      CMD_INIT: begin
        if (s.initialized) begin
          st = ST_STATE;
        end else begin
          n = clear_bus(s);
          if (req_i.port_status != 2'd0) begin
            st = ST_IO;
          end else begin
            n.bus_mode    = MODE_IDLE;
            n.initialized = 1'b1;
          end
        end
      end
      CMD_DEINIT: begin
        st = idle_st;
        if (idle_st == ST_OK) begin
          n = clear_bus(s);
        end
      end
      CMD_BIND: begin
        st = idle_st;
        if (idle_st == ST_OK) begin
          n.sink_bound = req_i.sink_flag;
        end
      end
      CMD_ENABLE: begin
        st = idle_st;
        if (idle_st == ST_OK && !s.enabled) begin
          if (!cur_ch_ok) begin
            st = ST_STATE;
          end else begin
            n.enabled = 1'b1;
          end
        end
      end
      CMD_DISABLE: begin
        st = idle_st;
        if (idle_st == ST_OK) begin
          n.enabled = 1'b0;
        end
      end
      CMD_SELECT: begin
        st = idle_st;
        if (idle_st == ST_OK) begin
          if (!req_ch_ok) begin
            st = ST_PARAM;
          end else begin
            n.sel_pins    = req_i.channel[1:0];
            n.cur_channel = req_i.channel;
          end
        end
      end
      CMD_GETCHAN: begin
        if (!s.initialized) begin
          st = ST_NOT_INIT;
        end
      end
      CMD_TX: begin
        if (req_i.length == '0) begin
          st = ST_PARAM;
        end else if (start_fail) begin
          st = start_st;
        end else begin
          st        = port_st;
          n.tx_busy = (port_st == ST_OK);
          n.bus_mode = sync_mode(s.bus_mode, n.tx_busy, s.rx_busy);
        end
      end
      CMD_RX: begin
        if (req_i.length == '0) begin
          st = ST_PARAM;
        end else if (start_fail) begin
          st = start_st;
        end else begin
          st         = port_st;
          n.rx_busy  = (port_st == ST_OK);
          n.rx_limit = (port_st == ST_OK) ? req_i.length : 16'd0;
          n.bus_mode = sync_mode(s.bus_mode, s.tx_busy, n.rx_busy);
        end
      end
      CMD_ABORT: begin
        if (!s.initialized) begin
          st = ST_NOT_INIT;
        end else if (!(s.bus_mode == MODE_IDLE && !s.tx_busy && !s.rx_busy)) begin
          n.tx_busy     = 1'b0;
          n.rx_busy     = 1'b0;
          n.rx_limit    = '0;
          n.cur_channel = NO_CHANNEL;
          st            = port_st;
          n.bus_mode    = (port_st == ST_OK) ? MODE_IDLE : MODE_ERROR;
        end
      end
      CMD_TXDONE: begin
        if (s.initialized && s.tx_busy) begin
          n.tx_busy  = 1'b0;
          n.bus_mode = sync_mode(s.bus_mode, 1'b0, s.rx_busy);
          ev_valid   = s.sink_bound;
        end
      end
      CMD_RXDONE: begin
        if (s.initialized && s.rx_busy) begin
          n.rx_busy  = 1'b0;
          n.rx_limit = '0;
          ev_valid   = s.sink_bound;
          // received length beyond capacity is an overflow fault
          if (req_i.length > s.rx_limit) begin
            n.bus_mode    = MODE_ERROR;
            n.cur_channel = NO_CHANNEL;
            st            = ST_OVERFLOW;
            if (s.sink_bound) begin
              ev_kind   = EV_FAULT;
              ev_status = ST_OVERFLOW;
              ev_length = req_i.length;
            end
          end else begin
            n.bus_mode = sync_mode(s.bus_mode, s.tx_busy, 1'b0);
            if (s.sink_bound) begin
              ev_kind   = EV_RX_DONE;
              ev_length = req_i.length;
            end
          end
        end
      end
      CMD_ERROR: begin
        if (s.initialized && (s.tx_busy || s.rx_busy)) begin
          n.tx_busy     = 1'b0;
          n.rx_busy     = 1'b0;
          n.rx_limit    = '0;
          n.bus_mode    = MODE_ERROR;
          n.cur_channel = NO_CHANNEL;
          st            = ST_IO;
          ev_valid      = s.sink_bound;
          if (s.sink_bound) begin
            ev_kind   = EV_FAULT;
            ev_status = ST_IO;
            ev_error  = req_i.raw_error;
          end
        end
      end
      default: begin
        st = ST_PARAM;
      end
    endcase
  end

  // result reports the state after the command
  assign state_o                = n;
  assign result_o.status        = st;
  assign result_o.bus_state     = n.bus_mode;
  assign result_o.channel_out   = n.cur_channel;
  assign result_o.mux_enabled   = n.enabled;
  assign result_o.select_lines  = n.sel_pins;
  assign result_o.ev_valid      = ev_valid;
  assign result_o.ev_kind       = ev_kind;
  assign result_o.ev_status     = ev_status;
  assign result_o.ev_length     = ev_length;
  assign result_o.ev_error      = ev_error;

endmodule

// File: sv/uart_mux_transaction_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_mux_transaction_controller_unit
// Command controller for a four-way uart mux and a shared transfer engine.
//
//   channel   direction  carries
//   s_axis    in         one command request (tuser = command code)
//   m_axis    out        status, bus view and optional event (tuser = kind)
//
// One request is taken per cycle while s_axis_tready is high; its result
// appears in the output register on the next cycle. The decode is a single
// combinational pass from the controller state into the result register.
// s_axis_tready is high while the output register is empty or being taken,
// so a stall on m_axis holds one result and back-pressures the input.
// Reset clears the controller state and empties the output register.
// ----------------------------------------------------------------------------
module uart_mux_transaction_controller_unit #(
  parameter int CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[2:0], length[18:3], port_status[20:19], raw_error[52:21],
  // sink_flag[53], zero fill [55:54]
  input  logic [55:0] s_axis_tdata,
  // command[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], bus_state[4:3], channel_out[7:5], mux_enabled[8],
  // select_lines[10:9], event_valid[11], event_status[14:12],
  // event_length[30:15], event_raw_error[62:31], zero fill [63]
  output logic [63:0] m_axis_tdata,
  // event_kind[1:0]
  output logic [1:0]  m_axis_tuser
);
  import umtc_pkg::*;

  umtc_state_t  state_q;
  umtc_state_t  state_d;
  umtc_req_t    req;
  umtc_result_t result_d;
  umtc_result_t result_q;
  logic         out_valid_q;
  logic         in_fire;

  // request unpack
  assign req.command     = s_axis_tuser;
  assign req.channel     = s_axis_tdata[2:0];
  assign req.length      = s_axis_tdata[18:3];
  assign req.port_status = s_axis_tdata[20:19];
  assign req.raw_error   = s_axis_tdata[52:21];
  assign req.sink_flag   = s_axis_tdata[53];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  umtc_step #(
    .CHANNELS(CHANNELS)
  ) u_step (
    .state_i (state_q),
    .req_i   (req),
    .state_o (state_d),
    .result_o(result_d)
  );

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.initialized <= 1'b0;
      state_q.bus_mode    <= MODE_UNINIT;
      state_q.enabled     <= 1'b0;
      state_q.cur_channel <= NO_CHANNEL;
      state_q.sel_pins    <= '0;
      state_q.tx_busy     <= 1'b0;
      state_q.rx_busy     <= 1'b0;
      state_q.rx_limit    <= '0;
      state_q.sink_bound  <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  // result pack
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.ev_kind;
  assign m_axis_tdata  = {1'b0,
                          result_q.ev_error,
                          result_q.ev_length,
                          result_q.ev_status,
                          result_q.ev_valid,
                          result_q.select_lines,
                          result_q.mux_enabled,
                          result_q.channel_out,
                          result_q.bus_state,
                          result_q.status};

  // uninitialised controller has no mode and no transfer in flight
  a_uninit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.initialized |-> (state_q.bus_mode == MODE_UNINIT) &&
                             !state_q.tx_busy && !state_q.rx_busy)
    else $error("uninitialised controller holds activity");

  // rx capacity only held while a receive is running
  a_rx_limit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.rx_busy |-> (state_q.rx_limit == '0))
    else $error("rx capacity left over without a receive");

  // an accepted request always lands in the output register
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request produced no result");

  // overflow result reports a faulted bus with no channel
  a_overflow_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.status == ST_OVERFLOW) |->
      (result_q.bus_state == MODE_ERROR) && (result_q.channel_out == NO_CHANNEL))
    else $error("overflow result with inconsistent bus view");

  // active mode implies a transfer flag
  a_active_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.bus_mode == MODE_ACTIVE) |-> (state_q.tx_busy || state_q.rx_busy))
    else $error("active mode without transfer");

endmodule

// File: tb/uart_mux_transaction_controller_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_mux_transaction_controller_unit_tb
// Self-checking bench for the uart mux transaction controller. A short table
// of directed commands covers reset values, field extremes and every error
// path. A long random phase follows, steered by a shadow copy of the
// controller so that most requests form real bind/select/enable/transfer
// sequences. Each request's result is predicted on acceptance and compared
// field by field with what leaves the master side, under random stalls.
// ----------------------------------------------------------------------------
module uart_mux_transaction_controller_unit_tb;
  import umtc_pkg::*;

  localparam int          NUM_CHANNELS   = 4;
  localparam int          RANDOM_ITEMS   = 1100;
  localparam int          HOLD_OFF_LEN   = 300;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          CYCLE_LIMIT    = 500000;
  localparam logic [3:0]  CMD_CODE_MAX   = 4'hF;
  localparam logic [1:0]  PORT_OK        = 2'd0;
  localparam logic [1:0]  PORT_BUSY      = 2'd1;
  localparam logic [1:0]  PORT_TIMEOUT   = 2'd2;
  localparam logic [1:0]  PORT_IO        = 2'd3;

  // one row of the directed table
  typedef struct packed {
    umtc_req_t    req;
    logic         has_want;
    umtc_result_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  umtc_state_t  ctl;
  umtc_result_t expected_results[$];
  stim_row_t    directed_rows[$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  logic         tx_calm;
  logic         rx_calm;
  logic         hold_off_req;

  uart_mux_transaction_controller_unit #(
    .CHANNELS(NUM_CHANNELS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic umtc_req_t make_req(input logic [3:0] cmd, input logic [2:0] ch,
                                         input logic [15:0] len, input logic [1:0] port,
                                         input logic [31:0] perr, input logic sink);
    umtc_req_t q;
    q.command     = cmd;
    q.channel     = ch;
    q.length      = len;
    q.port_status = port;
    q.raw_error   = perr;
    q.sink_flag   = sink;
    return q;
  endfunction

  // result with no event attached
  function automatic umtc_result_t make_res(input status_e st, input mode_e md,
                                            input logic [2:0] ch, input logic en,
                                            input logic [1:0] sel);
    umtc_result_t r;
    r              = '0;
    r.status       = st;
    r.bus_state    = md;
    r.channel_out  = ch;
    r.mux_enabled  = en;
    r.select_lines = sel;
    return r;
  endfunction

  // bus reset of the shadow state, select lines keep their level
  function automatic void clear_shadow_bus();
    ctl.initialized = 1'b0;
    ctl.enabled     = 1'b0;
    ctl.cur_channel = NO_CHANNEL;
    ctl.bus_mode    = MODE_UNINIT;
    ctl.tx_busy     = 1'b0;
    ctl.rx_busy     = 1'b0;
    ctl.rx_limit    = '0;
    ctl.sink_bound  = 1'b0;
  endfunction

  // error mode is sticky, otherwise follow the activity flags
  function automatic void follow_activity();
    if (ctl.bus_mode != MODE_ERROR) begin
      ctl.bus_mode = (ctl.tx_busy || ctl.rx_busy) ? MODE_ACTIVE : MODE_IDLE;
    end
  endfunction

  // gate for starting a transfer in one direction
  function automatic status_e start_status(input logic dir_busy);
    if (!ctl.initialized) begin
      return ST_NOT_INIT;
    end else if (ctl.bus_mode == MODE_ERROR || ctl.bus_mode == MODE_UNINIT) begin
      return ST_STATE;
    end else if (dir_busy) begin
      return ST_BUSY;
    end else if (!ctl.enabled || ctl.cur_channel >= NUM_CHANNELS || !ctl.sink_bound) begin
      return ST_STATE;
    end
    return ST_OK;
  endfunction

  // advance the shadow controller by one request and return its result
  function automatic umtc_result_t apply_command(input umtc_req_t req);
    umtc_result_t r;
    status_e      st;
    status_e      idle_st;
    status_e      port_st;
    logic         ev_on;
    ev_kind_e     ev_kind;
    status_e      ev_st;
    logic [15:0]  ev_len;
    logic [31:0]  ev_err;
    r       = '0;
    st      = ST_OK;
    ev_on   = 1'b0;
    ev_kind = EV_TX_DONE;
    ev_st   = ST_OK;
    ev_len  = '0;
    ev_err  = '0;
    // control commands need an initialised, quiet, idle bus
    if (!ctl.initialized) begin
      idle_st = ST_NOT_INIT;
    end else if (ctl.bus_mode == MODE_ACTIVE || ctl.tx_busy || ctl.rx_busy) begin
      idle_st = ST_BUSY;
    end else if (ctl.bus_mode != MODE_IDLE) begin
      idle_st = ST_STATE;
    end else begin
      idle_st = ST_OK;
    end
    case (req.port_status)
      PORT_OK:      port_st = ST_OK;
      PORT_BUSY:    port_st = ST_BUSY;
      PORT_TIMEOUT: port_st = ST_TIMEOUT;
      default:      port_st = ST_IO;
    endcase

    case (req.command)
      CMD_INIT: begin
        if (ctl.initialized) begin
          st = ST_STATE;
        end else begin
          clear_shadow_bus();
          if (req.port_status != PORT_OK) begin
            st = ST_IO;
          end else begin
            ctl.bus_mode    = MODE_IDLE;
            ctl.initialized = 1'b1;
          end
        end
      end
      CMD_DEINIT: begin
        st = idle_st;
        if (st == ST_OK) clear_shadow_bus();
      end
      CMD_BIND: begin
        st = idle_st;
        if (st == ST_OK) ctl.sink_bound = req.sink_flag;
      end
      CMD_ENABLE: begin
        st = idle_st;
        if (st == ST_OK && !ctl.enabled) begin
          if (ctl.cur_channel >= NUM_CHANNELS) st = ST_STATE;
          else ctl.enabled = 1'b1;
        end
      end
      CMD_DISABLE: begin
        st = idle_st;
        if (st == ST_OK) ctl.enabled = 1'b0;
      end
      CMD_SELECT: begin
        st = idle_st;
        if (st == ST_OK) begin
          if (req.channel >= NUM_CHANNELS) begin
            st = ST_PARAM;
          end else if (ctl.cur_channel != req.channel) begin
            ctl.sel_pins    = req.channel[1:0];
            ctl.cur_channel = req.channel;
          end
        end
      end
      CMD_GETCHAN: begin
        if (!ctl.initialized) st = ST_NOT_INIT;
      end
      CMD_TX: begin
        if (req.length == '0) begin
          st = ST_PARAM;
        end else begin
          st = start_status(ctl.tx_busy);
          if (st == ST_OK) begin
            st = port_st;
            ctl.tx_busy = (port_st == ST_OK);
            follow_activity();
          end
        end
      end
      CMD_RX: begin
        if (req.length == '0) begin
          st = ST_PARAM;
        end else begin
          st = start_status(ctl.rx_busy);
          if (st == ST_OK) begin
            st = port_st;
            ctl.rx_busy  = (port_st == ST_OK);
            ctl.rx_limit = (port_st == ST_OK) ? req.length : '0;
            follow_activity();
          end
        end
      end
      CMD_ABORT: begin
        if (!ctl.initialized) begin
          st = ST_NOT_INIT;
        end else if (!(ctl.bus_mode == MODE_IDLE && !ctl.tx_busy && !ctl.rx_busy)) begin
          ctl.tx_busy     = 1'b0;
          ctl.rx_busy     = 1'b0;
          ctl.rx_limit    = '0;
          ctl.cur_channel = NO_CHANNEL;
          st              = port_st;
          ctl.bus_mode    = (port_st == ST_OK) ? MODE_IDLE : MODE_ERROR;
        end
      end
      CMD_TXDONE: begin
        if (ctl.initialized && ctl.tx_busy) begin
          ctl.tx_busy = 1'b0;
          follow_activity();
          ev_on   = 1'b1;
          ev_kind = EV_TX_DONE;
        end
      end
      CMD_RXDONE: begin
        if (ctl.initialized && ctl.rx_busy) begin
          ev_on  = 1'b1;
          ev_len = req.length;
          if (req.length > ctl.rx_limit) begin
            // overflow drops the bus into error
            ctl.bus_mode    = MODE_ERROR;
            ctl.cur_channel = NO_CHANNEL;
            st              = ST_OVERFLOW;
            ev_kind         = EV_FAULT;
            ev_st           = ST_OVERFLOW;
          end else begin
            ev_kind = EV_RX_DONE;
          end
          ctl.rx_busy  = 1'b0;
          ctl.rx_limit = '0;
          follow_activity();
        end
      end
      CMD_ERROR: begin
        if (ctl.initialized && (ctl.tx_busy || ctl.rx_busy)) begin
          ctl.tx_busy     = 1'b0;
          ctl.rx_busy     = 1'b0;
          ctl.rx_limit    = '0;
          ctl.bus_mode    = MODE_ERROR;
          ctl.cur_channel = NO_CHANNEL;
          st              = ST_IO;
          ev_on           = 1'b1;
          ev_kind         = EV_FAULT;
          ev_st           = ST_IO;
          ev_err          = req.raw_error;
        end
      end
      default: st = ST_PARAM;
    endcase

    r.status       = st;
    r.bus_state    = ctl.bus_mode;
    r.channel_out  = ctl.cur_channel;
    r.mux_enabled  = ctl.enabled;
    r.select_lines = ctl.sel_pins;
    // events only reach a bound sink
    if (ev_on && ctl.sink_bound) begin
      r.ev_valid  = 1'b1;
      r.ev_kind   = ev_kind;
      r.ev_status = ev_st;
      r.ev_length = ev_len;
      r.ev_error  = ev_err;
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return 16'hFFFF;
    if (r < 30) return 16'($urandom());
    return 16'($urandom_range(1, 64));
  endfunction

  // random request, mostly the next sensible step for the current bus state
  function automatic umtc_req_t next_random_request();
    umtc_req_t   q;
    int unsigned pick;
    q.channel     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NUM_CHANNELS, 7))
                                                : 3'($urandom_range(0, NUM_CHANNELS - 1));
    q.length      = pick_length();
    q.port_status = ($urandom_range(0, 9) < 8) ? PORT_OK : 2'($urandom_range(1, 3));
    q.raw_error   = $urandom();
    q.sink_flag   = ($urandom_range(0, 9) != 0);
    pick          = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise, unknown codes included
      q.command = 4'($urandom_range(0, CMD_CODE_MAX));
    end else if (!ctl.initialized) begin
      q.command = (pick < 90) ? CMD_INIT : CMD_GETCHAN;
    end else if (ctl.bus_mode == MODE_ERROR) begin
      if (pick < 70) q.command = CMD_ABORT;
      else if (pick < 76) q.command = CMD_DEINIT;
      else if (pick < 82) q.command = CMD_TXDONE;
      else if (pick < 88) q.command = CMD_BIND;
      else if (pick < 94) q.command = CMD_TX;
      else q.command = CMD_GETCHAN;
    end else if (ctl.tx_busy || ctl.rx_busy) begin
      if (pick < 30) q.command = ctl.rx_busy ? CMD_RXDONE : CMD_TXDONE;
      else if (pick < 48) q.command = CMD_TXDONE;
      else if (pick < 60) q.command = CMD_RX;
      else if (pick < 70) q.command = CMD_TX;
      else if (pick < 78) q.command = CMD_ERROR;
      else if (pick < 86) q.command = CMD_ABORT;
      else if (pick < 92) q.command = CMD_SELECT;
      else q.command = CMD_RXDONE;
      // received length mostly within capacity, sometimes beyond
      if (q.command == CMD_RXDONE && ctl.rx_busy) begin
        q.length = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, ctl.rx_limit))
                                               : 16'($urandom_range(ctl.rx_limit, 16'hFFFF));
      end
    end else if (!ctl.sink_bound) begin
      q.command = CMD_BIND;
    end else if (ctl.cur_channel >= NUM_CHANNELS) begin
      q.command = CMD_SELECT;
    end else if (!ctl.enabled) begin
      q.command = CMD_ENABLE;
    end else begin
      if (pick < 38) q.command = CMD_TX;
      else if (pick < 66) q.command = CMD_RX;
      else if (pick < 74) q.command = CMD_SELECT;
      else if (pick < 78) q.command = CMD_BIND;
      else if (pick < 82) q.command = CMD_DISABLE;
      else if (pick < 85) q.command = CMD_DEINIT;
      else if (pick < 89) q.command = CMD_GETCHAN;
      else if (pick < 92) q.command = CMD_ABORT;
      else if (pick < 96) q.command = CMD_ENABLE;
      else q.command = CMD_TXDONE;
    end
    return q;
  endfunction

  // offer one request and record its expected result on acceptance
  task automatic drive_request(input umtc_req_t req, input logic has_want,
                               input umtc_result_t want);
    umtc_result_t predicted;
    int unsigned  gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, req.sink_flag, req.raw_error, req.port_status,
                     req.length, req.channel};
    s_axis_tuser  = req.command;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_command(req);
    expected_results.push_back(has_want ? want : predicted);
    @(negedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    umtc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: tdata 0x%0h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status",          32'(want.status),       32'(m_axis_tdata[2:0]));
        check_field("bus_state",       32'(want.bus_state),    32'(m_axis_tdata[4:3]));
        check_field("channel_out",     32'(want.channel_out),  32'(m_axis_tdata[7:5]));
        check_field("mux_enabled",     32'(want.mux_enabled),  32'(m_axis_tdata[8]));
        check_field("select_lines",    32'(want.select_lines), 32'(m_axis_tdata[10:9]));
        check_field("event_valid",     32'(want.ev_valid),     32'(m_axis_tdata[11]));
        check_field("event_status",    32'(want.ev_status),    32'(m_axis_tdata[14:12]));
        check_field("event_length",    32'(want.ev_length),    32'(m_axis_tdata[30:15]));
        check_field("event_raw_error", want.ev_error,          m_axis_tdata[62:31]);
        check_field("event_kind",      32'(want.ev_kind),      32'(m_axis_tuser));
        check_field("zero fill",       '0,                     32'(m_axis_tdata[63]));
      end
    end
  end

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    rx_calm       = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk_i);
      end
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
    end
  end

  // run limit
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    error_count     = 0;
    tx_calm         = 1'b0;
    hold_off_req    = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    ctl             = '0;
    ctl.bus_mode    = MODE_UNINIT;
    ctl.cur_channel = NO_CHANNEL;
    rst_ni          = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: reset view, extremes and error paths typed in
    directed_rows.push_back('{make_req(CMD_GETCHAN, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b1,
                              make_res(ST_NOT_INIT, MODE_UNINIT, NO_CHANNEL, 1'b0, 2'b00)});
    directed_rows.push_back('{make_req(CMD_TX, 3'd7, 16'd0, PORT_OK, 32'd0, 1'b1), 1'b1,
                              make_res(ST_PARAM, MODE_UNINIT, NO_CHANNEL, 1'b0, 2'b00)});
    directed_rows.push_back('{make_req(CMD_CODE_MAX, 3'd7, 16'hFFFF, PORT_IO, 32'hFFFFFFFF,
                                       1'b1), 1'b1,
                              make_res(ST_PARAM, MODE_UNINIT, NO_CHANNEL, 1'b0, 2'b00)});
    directed_rows.push_back('{make_req(CMD_TXDONE, 3'd0, 16'd1, PORT_OK, 32'd0, 1'b0), 1'b1,
                              make_res(ST_OK, MODE_UNINIT, NO_CHANNEL, 1'b0, 2'b00)});
    directed_rows.push_back('{make_req(CMD_INIT, 3'd0, 16'd0, PORT_IO, 32'd0, 1'b0), 1'b1,
                              make_res(ST_IO, MODE_UNINIT, NO_CHANNEL, 1'b0, 2'b00)});
    directed_rows.push_back('{make_req(CMD_INIT, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b1,
                              make_res(ST_OK, MODE_IDLE, NO_CHANNEL, 1'b0, 2'b00)});
    directed_rows.push_back('{make_req(CMD_INIT, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b1,
                              make_res(ST_STATE, MODE_IDLE, NO_CHANNEL, 1'b0, 2'b00)});
    directed_rows.push_back('{make_req(CMD_SELECT, 3'd7, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b1,
                              make_res(ST_PARAM, MODE_IDLE, NO_CHANNEL, 1'b0, 2'b00)});
    // the rest are checked against the predictor
    directed_rows.push_back('{make_req(CMD_ENABLE, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_SELECT, 3'd3, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_BIND, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b1), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_ENABLE, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_TX, 3'd0, 16'hFFFF, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_RX, 3'd0, 16'd1, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_BIND, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_RXDONE, 3'd0, 16'hFFFF, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_TXDONE, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_ABORT, 3'd0, 16'd0, PORT_TIMEOUT, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_ABORT, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_SELECT, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_TX, 3'd0, 16'd1, PORT_BUSY, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_RX, 3'd0, 16'd5, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_ERROR, 3'd0, 16'd0, PORT_OK, 32'hFFFFFFFF, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_req(CMD_ABORT, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    directed_rows.push_back('{make_req(CMD_DEINIT, 3'd0, 16'd0, PORT_OK, 32'd0, 1'b0), 1'b0,
                              '0});
    foreach (directed_rows[i]) begin
      drive_request(directed_rows[i].req, directed_rows[i].has_want, directed_rows[i].want);
    end

    // sender pauses until the directed results are all back
    s_axis_tvalid = 1'b0;
    wait (expected_results.size() == 0);
    @(negedge clk_i);

    // random phase
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      if (i == 300) begin
        // long receiver hold-off while requests keep coming
        tx_calm      = 1'b1;
        hold_off_req = 1'b1;
      end
      if (i == 700) begin
        s_axis_tvalid = 1'b0;
        wait (expected_results.size() == 0);
        @(negedge clk_i);
      end
      drive_request(next_random_request(), 1'b0, '0);
    end
    s_axis_tvalid = 1'b0;

    // drain
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
sv/umtc_pkg.sv
sv/umtc_step.sv
sv/uart_mux_transaction_controller_unit.sv
tb/uart_mux_transaction_controller_unit_tb.sv
